// ----- rtl/sbd_pkg.sv -----
// sbd_pkg: types, constants and codes shared by the brick directory allocator
// no dependencies
package sbd_pkg;

  localparam int MAX_GRID_EDGE     = 64;
  localparam int BRICK_EDGE        = 4;
  localparam int DIRECTORY_ENTRIES = 4096;
  localparam int SLOT_COUNT        = 4096;

  localparam int DIR_AW  = 12;   // directory address bits
  localparam int SLOT_W  = 12;
  localparam int CNT_W   = 13;
  localparam int EDGE_W  = 7;

  localparam logic [63:0] HASH_OFFSET = 64'd1469598103934665603;
  // prime is 2^40 + 435: shift plus a narrow multiply
  localparam int          HASH_SHIFT  = 40;
  localparam logic [8:0]  HASH_LOW    = 9'd435;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_FIND    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_SPARE   = 2'd3;   // unassigned code, behaves as find

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic [1:0] REG_GRID_W     = 2'd0;
  localparam logic [1:0] REG_GRID_H     = 2'd1;
  localparam logic [1:0] REG_GRID_D     = 2'd2;
  localparam logic [1:0] REG_MAX_BRICKS = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [17:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] brick_slot;
    logic [5:0]  local_index;
    logic [12:0] allocated_count;
    logic [31:0] failure_count;
    logic [63:0] order_hash;
  } res_t;

  typedef struct packed {
    logic latch_in;
    logic sweep;
    logic clr_done;
    logic mul1;
    logic mul2;
    logic chk;
    logic div_start;
    logic div_sel;
    logic latch_div1;
    logic latch_div2;
    logic dir1;
    logic dir2;
    logic rd;
    logic decide;
    logic hash;
    logic load_out;
  } sbd_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic sweep_last;
    logic idx_oor;
    logic dir_oor;
    logic div_done;
    logic alloc;
    logic out_free;
  } sbd_stat_t;

endpackage

// ----- rtl/sbd_div.sv -----
// sbd_div: restoring divider, one quotient bit per cycle, quotient below 128
// no dependencies
module sbd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [18:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [6:0]  quot,
  output logic [12:0] rem
);

  logic [18:0] acc;
  logic [12:0] dsr;
  logic [2:0]  bitpos;
  logic        busy;
  logic [19:0] shifted;
  logic        ge;

  assign shifted = 20'(dsr) << bitpos;
  assign ge      = {1'b0, acc} >= shifted;
  assign rem     = acc[12:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitpos == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= dividend;
      dsr    <= divisor;
      bitpos <= 3'd6;
      quot   <= '0;
    end else if (busy) begin
      if (ge) begin
        acc          <= acc - shifted[18:0];
        quot[bitpos] <= 1'b1;
      end
      if (bitpos != 3'd0) begin
        bitpos <= bitpos - 3'd1;
      end
    end
  end

endmodule

// ----- rtl/sbd_datapath.sv -----
// sbd_datapath: config registers, coordinate math, directory memory, counters,
// hash and result register; depends on sbd_pkg and sbd_div
module sbd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  sbd_pkg::cmd_t       cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output sbd_pkg::res_t       res,
  input  sbd_pkg::sbd_cmd_t   ctl,
  output sbd_pkg::sbd_stat_t  stat
);

  logic [6:0]  grid_w, grid_h, grid_d;
  logic [12:0] max_bricks;

  logic [1:0]  op;
  logic [17:0] idx;
  logic [6:0]  ew, eh, ed;
  logic [12:0] plane;
  logic [18:0] cells;
  logic [6:0]  zc, yc, xc;
  logic [4:0]  bw, bh;
  logic [7:0]  tmid;
  logic [12:0] dir;
  logic [11:0] sweep_addr;

  logic [12:0] mem [sbd_pkg::DIRECTORY_ENTRIES];
  logic [12:0] rd_data;

  logic [12:0] count;
  logic [31:0] refused;
  logic [63:0] hash;
  logic [63:0] prod;

  logic [2:0]  st;
  logic [11:0] slot;
  logic [5:0]  loc;

  logic        div_start;
  logic [18:0] div_a;
  logic [12:0] div_b;
  logic        div_done;
  logic [6:0]  div_q;
  logic [12:0] div_r;
  logic        at_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w     <= 7'd64;
      grid_h     <= 7'd64;
      grid_d     <= 7'd64;
      max_bricks <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbd_pkg::REG_GRID_W:     grid_w     <= cfg_data[6:0];
        sbd_pkg::REG_GRID_H:     grid_h     <= cfg_data[6:0];
        sbd_pkg::REG_GRID_D:     grid_d     <= cfg_data[6:0];
        sbd_pkg::REG_MAX_BRICKS: max_bricks <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate edges to the maximum grid edge
  assign ew = (grid_w > 7'(sbd_pkg::MAX_GRID_EDGE)) ? 7'(sbd_pkg::MAX_GRID_EDGE) : grid_w;
  assign eh = (grid_h > 7'(sbd_pkg::MAX_GRID_EDGE)) ? 7'(sbd_pkg::MAX_GRID_EDGE) : grid_h;
  assign ed = (grid_d > 7'(sbd_pkg::MAX_GRID_EDGE)) ? 7'(sbd_pkg::MAX_GRID_EDGE) : grid_d;
  assign bw = 5'((8'(ew) + 8'd3) >> 2);
  assign bh = 5'((8'(eh) + 8'd3) >> 2);

  assign div_start = ctl.div_start;
  assign div_a     = ctl.div_sel ? 19'(div_r) : {1'b0, idx};
  assign div_b     = ctl.div_sel ? 13'(ew) : plane;

  sbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      op  <= cmd.op;
      idx <= cmd.cell_index;
    end
    if (ctl.mul1)       plane <= 13'(ew) * 13'(eh);
    if (ctl.mul2)       cells <= 19'(plane) * 19'(ed);
    if (ctl.latch_div1) zc <= div_q;
    if (ctl.latch_div2) begin
      yc <= div_q;
      xc <= div_r[6:0];
    end
    if (ctl.dir1) tmid <= 8'(yc[6:2]) + 8'(bh) * 8'(zc[6:2]);
    if (ctl.dir2) dir  <= 13'(xc[6:2]) + 13'(bw) * 13'(tmid);
  end

  // directory memory: valid flag and slot per brick
  always_ff @(posedge clk) begin
    if (ctl.sweep) begin
      mem[sweep_addr] <= '0;
    end else if (ctl.decide && stat.alloc) begin
      mem[dir[11:0]] <= {1'b1, count[11:0]};
    end
    if (ctl.rd) rd_data <= mem[dir[11:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) sweep_addr <= '0;
    else if (ctl.sweep) sweep_addr <= sweep_addr + 12'd1;
  end

  assign at_limit = (max_bricks != '0 && count >= max_bricks) ||
                    (count >= 13'(sbd_pkg::SLOT_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      refused <= '0;
      hash    <= '0;
    end else if (ctl.clr_done) begin
      count   <= '0;
      refused <= '0;
      hash    <= '0;
    end else begin
      if (ctl.decide && stat.alloc) count <= count + 13'd1;
      if (ctl.decide && !rd_data[12] && op == sbd_pkg::OP_ACQUIRE && at_limit &&
          refused != '1) begin
        refused <= refused + 32'd1;
      end
      if (ctl.hash) begin
        hash <= ((hash << sbd_pkg::HASH_SHIFT) + prod) ^ (64'(dir) + sbd_pkg::HASH_OFFSET);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decide) prod <= hash * 64'(sbd_pkg::HASH_LOW);
  end

  // per-item result fields
  always_ff @(posedge clk) begin
    if (ctl.clr_done) begin
      st   <= sbd_pkg::ST_CLEARED;
      slot <= '0;
      loc  <= '0;
    end else if ((ctl.chk && stat.idx_oor) || (ctl.rd && stat.dir_oor)) begin
      st   <= sbd_pkg::ST_RANGE;
      slot <= '0;
      loc  <= '0;
    end else if (ctl.decide) begin
      loc <= {zc[1:0], yc[1:0], xc[1:0]};
      if (rd_data[12]) begin
        st   <= sbd_pkg::ST_FOUND;
        slot <= rd_data[11:0];
      end else if (op != sbd_pkg::OP_ACQUIRE) begin
        st   <= sbd_pkg::ST_ABSENT;
        slot <= '0;
      end else if (at_limit) begin
        st   <= sbd_pkg::ST_LIMIT;
        slot <= '0;
      end else begin
        st   <= sbd_pkg::ST_NEW;
        slot <= count[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res.status          <= st;
      res.brick_slot      <= slot;
      res.local_index     <= loc;
      res.allocated_count <= count;
      res.failure_count   <= refused;
      res.order_hash      <= hash;
    end
  end

  assign stat.op_clear   = (cmd.op == sbd_pkg::OP_CLEAR);
  assign stat.sweep_last = (sweep_addr == '1);
  assign stat.idx_oor    = ({1'b0, idx} >= cells);
  assign stat.dir_oor    = (dir >= 13'(sbd_pkg::DIRECTORY_ENTRIES));
  assign stat.div_done   = div_done;
  assign stat.alloc      = !rd_data[12] && op == sbd_pkg::OP_ACQUIRE && !at_limit;
  assign stat.out_free   = !res_valid || !res_stall;

endmodule

// ----- rtl/sbd_ctrl.sv -----
// sbd_ctrl: sequencer for clearing, range check, division, lookup and update
// depends on sbd_pkg
module sbd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  sbd_pkg::sbd_stat_t  stat,
  output sbd_pkg::sbd_cmd_t   ctl
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIV1 = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_DIR1 = 4'd8;
  localparam logic [3:0] S_DIR2 = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_DEC  = 4'd11;
  localparam logic [3:0] S_HASH = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state, state_next;

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        ctl.sweep = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch_in = 1'b1;
          state_next   = stat.op_clear ? S_CLR : S_MUL1;
        end
      end
      S_CLR: begin
        ctl.sweep = 1'b1;
        if (stat.sweep_last) begin
          ctl.clr_done = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_MUL1: begin
        ctl.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul2   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        ctl.chk = 1'b1;
        if (stat.idx_oor) begin
          state_next = S_OUT;
        end else begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          ctl.latch_div1 = 1'b1;
          ctl.div_start  = 1'b1;
          ctl.div_sel    = 1'b1;
          state_next     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (stat.div_done) begin
          ctl.latch_div2 = 1'b1;
          state_next     = S_DIR1;
        end
      end
      S_DIR1: begin
        ctl.dir1   = 1'b1;
        state_next = S_DIR2;
      end
      S_DIR2: begin
        ctl.dir2   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        ctl.rd     = 1'b1;
        state_next = stat.dir_oor ? S_OUT : S_DEC;
      end
      S_DEC: begin
        ctl.decide = 1'b1;
        state_next = stat.alloc ? S_HASH : S_OUT;
      end
      S_HASH: begin
        ctl.hash   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/sparse_brick_directory_allocator.sv -----
// sparse_brick_directory_allocator: top level joining sequencer and datapath
// depends on sbd_pkg, sbd_ctrl, sbd_datapath
//
// One item at a time. After reset all 4096 directory entries are swept
// before the first item is taken (cmd_stall stays high; config writes
// still land). A find or acquire, once taken, goes through two size
// multiplies, the range check, two divisions on the shared restoring
// divider (7 quotient bits each, then a done pulse; z from the plane
// size, then y and x from the width), the brick index math in S_DIR1
// and S_DIR2, one registered directory read, the decision, the hash
// update on a new allocation, and the output load. The sequencer goes
// back to idle after the load and only then takes the next item. An
// out-of-range cell goes from the range check straight to the output
// load. A clear sweeps all 4096 directory entries, one a cycle, then
// zeroes the counters and hash, and its status cleared is loaded. The
// result sits in an output register; while it is held by res_stall the
// next item runs up to its own load and waits there.
module sparse_brick_directory_allocator (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [12:0]     cfg_data,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  sbd_pkg::cmd_t   cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output sbd_pkg::res_t   res
);

  sbd_pkg::sbd_cmd_t  ctl;   // per-cycle commands from the sequencer
  sbd_pkg::sbd_stat_t stat;  // conditions the sequencer branches on

  sbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  sbd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

// ----- rtl/sbd_checker.sv -----
// sbd_checker: port-level assertions for the allocator, bound to the top level
// depends on sbd_pkg
module sbd_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input sbd_pkg::res_t res
);

  a_take_stall: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second item taken while one is in flight");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_cleared_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == sbd_pkg::ST_CLEARED |->
      res.allocated_count == '0 && res.failure_count == '0 && res.order_hash == '0)
    else $error("clear left counters set");

  a_new_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == sbd_pkg::ST_NEW |->
      13'(res.brick_slot) + 13'd1 == res.allocated_count)
    else $error("new slot does not match count");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.allocated_count <= 13'(sbd_pkg::SLOT_COUNT))
    else $error("allocated count above capacity");

endmodule

bind sparse_brick_directory_allocator sbd_checker u_sbd_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for the sparse brick directory allocator
// depends on sbd_pkg and sparse_brick_directory_allocator; a directed table, then random
// phases over grid and limit settings, checked against typed values or a directory model
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 40;   // longer than one find or acquire
  localparam int ITEMS_PER_PHASE = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = sbd_pkg::REG_GRID_W;
  logic [12:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  sbd_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  sbd_pkg::res_t res;

  sparse_brick_directory_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the directory and its counters
  bit          shadow_valid [sbd_pkg::DIRECTORY_ENTRIES];
  bit [11:0]   shadow_slot  [sbd_pkg::DIRECTORY_ENTRIES];
  bit [12:0]   shadow_count;
  bit [63:0]   shadow_hash;
  bit [31:0]   shadow_refused;
  bit [6:0]    cfg_w, cfg_h, cfg_d;
  bit [12:0]   cfg_max;

  sbd_pkg::res_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int clears_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recent_cells [$];

  typedef struct {
    bit            is_cfg;
    logic [1:0]    ridx;
    logic [12:0]   rval;
    sbd_pkg::cmd_t c;
    bit            typed;
    sbd_pkg::res_t r;
  } row_t;
  row_t plan [$];

  function automatic int unsigned clamp_edge(bit [6:0] v);
    return (v > sbd_pkg::MAX_GRID_EDGE) ? sbd_pkg::MAX_GRID_EDGE : v;
  endfunction

  function automatic void wipe_directory();
    for (int i = 0; i < sbd_pkg::DIRECTORY_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_slot[i] = '0;
    end
    shadow_count = '0;
    shadow_hash = '0;
    shadow_refused = '0;
  endfunction

  // applies one item to the shadow directory and returns what the block should answer
  function automatic sbd_pkg::res_t lookup_brick(sbd_pkg::cmd_t c);
    sbd_pkg::res_t o;
    int unsigned w, h, d, cells, plane, z, rem, y, x, bw, bh, dir;
    bit [5:0] loc;
    w = clamp_edge(cfg_w);
    h = clamp_edge(cfg_h);
    d = clamp_edge(cfg_d);
    o = '0;
    o.status = sbd_pkg::ST_RANGE;
    if (c.op == sbd_pkg::OP_CLEAR) begin
      wipe_directory();
      o.status = sbd_pkg::ST_CLEARED;
    end else begin
      cells = w * h * d;
      if (c.cell_index < cells) begin
        plane = w * h;
        z = c.cell_index / plane;
        rem = c.cell_index - z * plane;
        y = rem / w;
        x = rem - y * w;
        bw = (w + 3) / 4;
        bh = (h + 3) / 4;
        dir = x / 4 + bw * (y / 4 + bh * (z / 4));
        loc = 6'((x & 3) + 4 * ((y & 3) + 4 * (z & 3)));
        if (dir < sbd_pkg::DIRECTORY_ENTRIES) begin
          o.local_index = loc;
          if (shadow_valid[dir]) begin
            o.status = sbd_pkg::ST_FOUND;
            o.brick_slot = shadow_slot[dir];
          end else if (c.op != sbd_pkg::OP_ACQUIRE) begin
            // the spare op code lands here too, like find
            o.status = sbd_pkg::ST_ABSENT;
          end else if ((cfg_max != 0 && shadow_count >= cfg_max) ||
                       shadow_count >= sbd_pkg::SLOT_COUNT) begin
            o.status = sbd_pkg::ST_LIMIT;
            if (shadow_refused != 32'hFFFF_FFFF) shadow_refused++;
          end else begin
            o.status = sbd_pkg::ST_NEW;
            o.brick_slot = shadow_count[11:0];
            shadow_valid[dir] = 1'b1;
            shadow_slot[dir] = shadow_count[11:0];
            shadow_count++;
            shadow_hash = (shadow_hash * 64'd1099511628211) ^
                          (64'(dir) + sbd_pkg::HASH_OFFSET);
          end
        end
      end
    end
    o.allocated_count = shadow_count;
    o.failure_count = shadow_refused;
    o.order_hash = shadow_hash;
    return o;
  endfunction

  task automatic report_mismatch(string field, bit [63:0] got, bit [63:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    sbd_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(res.status), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status)
          report_mismatch("status", 64'(res.status), 64'(want.status));
        if (res.brick_slot !== want.brick_slot)
          report_mismatch("brick_slot", 64'(res.brick_slot), 64'(want.brick_slot));
        if (res.local_index !== want.local_index)
          report_mismatch("local_index", 64'(res.local_index), 64'(want.local_index));
        if (res.allocated_count !== want.allocated_count)
          report_mismatch("allocated_count", 64'(res.allocated_count),
                          64'(want.allocated_count));
        if (res.failure_count !== want.failure_count)
          report_mismatch("failure_count", 64'(res.failure_count),
                          64'(want.failure_count));
        if (res.order_hash !== want.order_hash)
          report_mismatch("order_hash", res.order_hash, want.order_hash);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("sparse_brick_directory_allocator test failed");
      $finish;
    end
  end

  // one item through the command handshake, expectation queued on acceptance
  task automatic send_item(sbd_pkg::cmd_t c, bit typed, sbd_pkg::res_t r);
    sbd_pkg::res_t pr;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    pr = lookup_brick(c);
    pending_results.push_back(typed ? r : pr);
    items_sent++;
    if (c.op == sbd_pkg::OP_CLEAR) clears_sent++;
  endtask

  // drop valid and let the block drain before touching registers
  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] ridx, logic [12:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ridx;
    cfg_data <= val;
    case (ridx)
      sbd_pkg::REG_GRID_W:     cfg_w = val[6:0];
      sbd_pkg::REG_GRID_H:     cfg_h = val[6:0];
      sbd_pkg::REG_GRID_D:     cfg_d = val[6:0];
      sbd_pkg::REG_MAX_BRICKS: cfg_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_cfg(logic [1:0] ridx, logic [12:0] val);
    row_t e;
    e = '{default: '0};
    e.is_cfg = 1'b1;
    e.ridx = ridx;
    e.rval = val;
    plan.push_back(e);
  endtask

  task automatic add_cmd(logic [1:0] op, logic [17:0] idx);
    row_t e;
    e = '{default: '0};
    e.c.op = op;
    e.c.cell_index = idx;
    plan.push_back(e);
  endtask

  task automatic add_typed(logic [1:0] op, logic [17:0] idx, logic [2:0] st,
                           logic [11:0] slot, logic [5:0] loc, logic [12:0] cnt,
                           logic [31:0] fails, logic [63:0] hash);
    row_t e;
    e = '{default: '0};
    e.c.op = op;
    e.c.cell_index = idx;
    e.typed = 1'b1;
    e.r = '{status: st, brick_slot: slot, local_index: loc, allocated_count: cnt,
            failure_count: fails, order_hash: hash};
    plan.push_back(e);
  endtask

  // random item shaped toward cells inside the configured grid
  function automatic sbd_pkg::cmd_t random_item();
    sbd_pkg::cmd_t c;
    int unsigned cells, pick;
    cells = clamp_edge(cfg_w) * clamp_edge(cfg_h) * clamp_edge(cfg_d);
    pick = $urandom_range(199);
    if (pick < 3) c.op = sbd_pkg::OP_CLEAR;
    else if (pick < 120) c.op = sbd_pkg::OP_ACQUIRE;
    else if (pick < 185) c.op = sbd_pkg::OP_FIND;
    else c.op = sbd_pkg::OP_SPARE;
    pick = $urandom_range(99);
    if (pick < 10 || cells == 0) begin
      c.cell_index = 18'($urandom);                       // any 18-bit pattern
    end else if (pick < 15) begin
      c.cell_index = 18'(cells - 1 + $urandom_range(2));  // around the grid end
    end else if (pick < 45 && recent_cells.size() > 0) begin
      c.cell_index = 18'(recent_cells[$urandom_range(recent_cells.size() - 1)]);
    end else begin
      c.cell_index = 18'($urandom_range(cells - 1));
    end
    recent_cells.push_back(int'(c.cell_index));
    if (recent_cells.size() > 48) void'(recent_cells.pop_front());
    return c;
  endfunction

  initial begin
    // grid edges and brick limit per random phase, extremes included
    int unsigned phase_cfg [9][4] = '{
      '{64, 64, 64, 0}, '{3, 5, 2, 2}, '{17, 11, 9, 40}, '{1, 64, 1, 0},
      '{64, 1, 64, 8191}, '{127, 127, 127, 4096}, '{8, 8, 8, 5}, '{0, 12, 12, 0},
      '{33, 22, 13, 1}
    };
    sbd_pkg::res_t none;
    none = '0;
    cfg_w = 7'd64;
    cfg_h = 7'd64;
    cfg_d = 7'd64;
    cfg_max = '0;
    wipe_directory();

    // directed part: reset state, extremes, limit and range cases
    add_typed(sbd_pkg::OP_FIND,    18'd0, sbd_pkg::ST_ABSENT,
              12'd0, 6'd0, 13'd0, 32'd0, 64'd0);
    add_typed(sbd_pkg::OP_ACQUIRE, 18'd0, sbd_pkg::ST_NEW,
              12'd0, 6'd0, 13'd1, 32'd0, sbd_pkg::HASH_OFFSET);
    add_typed(sbd_pkg::OP_FIND,    18'd0, sbd_pkg::ST_FOUND,
              12'd0, 6'd0, 13'd1, 32'd0, sbd_pkg::HASH_OFFSET);
    add_cmd(sbd_pkg::OP_ACQUIRE, 18'h3FFFF);             // far corner cell
    add_cmd(sbd_pkg::OP_SPARE, 18'h3FFFF);               // spare op code behaves as find
    add_cmd(sbd_pkg::OP_FIND, 18'd1);
    add_typed(sbd_pkg::OP_CLEAR,   18'h3FFFF, sbd_pkg::ST_CLEARED,
              12'd0, 6'd0, 13'd0, 32'd0, 64'd0);
    add_cfg(sbd_pkg::REG_MAX_BRICKS, 13'd1);
    add_cmd(sbd_pkg::OP_ACQUIRE, 18'd0);
    add_typed(sbd_pkg::OP_ACQUIRE, 18'd4, sbd_pkg::ST_LIMIT,
              12'd0, 6'd0, 13'd1, 32'd1, sbd_pkg::HASH_OFFSET);
    add_cfg(sbd_pkg::REG_GRID_W, 13'd2);
    add_cfg(sbd_pkg::REG_GRID_H, 13'd3);
    add_cfg(sbd_pkg::REG_GRID_D, 13'd1);
    add_typed(sbd_pkg::OP_ACQUIRE, 18'd6, sbd_pkg::ST_RANGE,
              12'd0, 6'd0, 13'd1, 32'd1, sbd_pkg::HASH_OFFSET);
    add_cmd(sbd_pkg::OP_ACQUIRE, 18'd5);
    add_cmd(sbd_pkg::OP_FIND, 18'd0);
    add_cfg(sbd_pkg::REG_GRID_W, 13'd0);                 // empty grid
    add_cmd(sbd_pkg::OP_ACQUIRE, 18'd0);
    add_cfg(sbd_pkg::REG_GRID_W, 13'd100);               // edge above the maximum
    add_cfg(sbd_pkg::REG_GRID_H, 13'd64);
    add_cfg(sbd_pkg::REG_GRID_D, 13'd64);
    add_cfg(sbd_pkg::REG_MAX_BRICKS, 13'd0);
    add_cmd(sbd_pkg::OP_ACQUIRE, 18'h3FFFF);
    add_cmd(sbd_pkg::OP_FIND, 18'h2AAAA);
    add_cmd(sbd_pkg::OP_ACQUIRE, 18'h15555);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].ridx, plan[i].rval);
      end else begin
        send_item(plan[i].c, plan[i].typed, plan[i].r);
      end
    end

    // random phases, each with its own grid, limit and idling mix
    for (int p = 0; p < 9; p++) begin
      settle();
      write_reg(sbd_pkg::REG_GRID_W, 13'(phase_cfg[p][0]));
      write_reg(sbd_pkg::REG_GRID_H, 13'(phase_cfg[p][1]));
      write_reg(sbd_pkg::REG_GRID_D, 13'(phase_cfg[p][2]));
      write_reg(sbd_pkg::REG_MAX_BRICKS, 13'(phase_cfg[p][3]));
      recent_cells.delete();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item(), 1'b0, none);
    end

    settle();
    $display("covered %0d items (%0d clears) over 9 random grid settings, %0d results checked",
             items_sent, clears_sent, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("sparse_brick_directory_allocator test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("sparse_brick_directory_allocator test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sbd_pkg.sv
rtl/sbd_div.sv
rtl/sbd_datapath.sv
rtl/sbd_ctrl.sv
rtl/sparse_brick_directory_allocator.sv
rtl/sbd_checker.sv
dv/tb_top.sv
